// ===== rtl/rie_pkg.sv =====
// ----------------------------------------------------------------------------
// rie_pkg
// Shared constants, opcodes, status codes and helpers of the integer
// execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rie_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int REG_COUNT = 16;
    localparam int REG_W     = $clog2(REG_COUNT);
    localparam int OFF_W     = $clog2(MEM_BYTES);
    localparam int ROW_W     = OFF_W - 2;
    localparam int ROWS      = MEM_BYTES / 4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_REG  = 3'd1;
    localparam logic [2:0] ST_MISALIGN = 3'd2;
    localparam logic [2:0] ST_BELOW    = 3'd3;
    localparam logic [2:0] ST_OUTSIDE  = 3'd4;
    localparam logic [2:0] ST_BAD_SHFT = 3'd5;
    localparam logic [2:0] ST_EXC_RET  = 3'd6;
    localparam logic [2:0] ST_UNKNOWN  = 3'd7;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;

    localparam logic [3:0] MM_ST_IND  = 4'd0;
    localparam logic [3:0] MM_LD_IND  = 4'd1;
    localparam logic [3:0] MM_ST_PRED = 4'd2;
    localparam logic [3:0] MM_LD_POST = 4'd3;
    localparam logic [3:0] MM_ST_DISP = 4'd4;
    localparam logic [3:0] MM_LD_DISP = 4'd5;
    localparam logic [3:0] MM_ST_IDX  = 4'd6;
    localparam logic [3:0] MM_LD_IDX  = 4'd7;
    localparam logic [3:0] MM_ST_GBR  = 4'd8;
    localparam logic [3:0] MM_LD_GBR  = 4'd9;

    localparam logic [6:0] OP_NOP    = 7'd0;
    localparam logic [6:0] OP_CLRT   = 7'd1;
    localparam logic [6:0] OP_SETT   = 7'd2;
    localparam logic [6:0] OP_MOVT   = 7'd3;
    localparam logic [6:0] OP_MOVI   = 7'd4;
    localparam logic [6:0] OP_ADDI   = 7'd5;
    localparam logic [6:0] OP_MOV    = 7'd6;
    localparam logic [6:0] OP_MEM_LO = 7'd7;
    localparam logic [6:0] OP_MEM_HI = 7'd36;
    localparam logic [6:0] OP_ADD    = 7'd37;
    localparam logic [6:0] OP_SUB    = 7'd38;
    localparam logic [6:0] OP_CMPEQ  = 7'd39;
    localparam logic [6:0] OP_CMPEQI = 7'd40;
    localparam logic [6:0] OP_CMPHS  = 7'd41;
    localparam logic [6:0] OP_CMPGE  = 7'd42;
    localparam logic [6:0] OP_CMPHI  = 7'd43;
    localparam logic [6:0] OP_CMPGT  = 7'd44;
    localparam logic [6:0] OP_CMPPZ  = 7'd45;
    localparam logic [6:0] OP_CMPPL  = 7'd46;
    localparam logic [6:0] OP_TST    = 7'd47;
    localparam logic [6:0] OP_AND    = 7'd48;
    localparam logic [6:0] OP_XOR    = 7'd49;
    localparam logic [6:0] OP_OR     = 7'd50;
    localparam logic [6:0] OP_TSTI   = 7'd51;
    localparam logic [6:0] OP_ANDI   = 7'd52;
    localparam logic [6:0] OP_XORI   = 7'd53;
    localparam logic [6:0] OP_ORI    = 7'd54;
    localparam logic [6:0] OP_NOT    = 7'd55;
    localparam logic [6:0] OP_NEG    = 7'd56;
    localparam logic [6:0] OP_SHL1   = 7'd57;
    localparam logic [6:0] OP_SHR1   = 7'd58;
    localparam logic [6:0] OP_SAR1   = 7'd59;
    localparam logic [6:0] OP_SHLN   = 7'd60;
    localparam logic [6:0] OP_SHRN   = 7'd61;
    localparam logic [6:0] OP_BRA    = 7'd62;
    localparam logic [6:0] OP_BT     = 7'd63;
    localparam logic [6:0] OP_BF     = 7'd64;
    localparam logic [6:0] OP_BSR    = 7'd65;
    localparam logic [6:0] OP_JMP    = 7'd66;
    localparam logic [6:0] OP_JSR    = 7'd67;
    localparam logic [6:0] OP_RTS    = 7'd68;
    localparam logic [6:0] OP_RTE    = 7'd69;
    localparam logic [6:0] OP_LDPCW  = 7'd70;
    localparam logic [6:0] OP_LDPCL  = 7'd71;
    localparam logic [6:0] OP_MOVA   = 7'd72;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [OFF_W-1:0] off;
        logic [1:0]       size;
        logic [31:0]      wdata;
    } t_mem_req;

    function automatic logic [31:0] sext(input logic [31:0] v, input logic [1:0] size);
        logic [31:0] r;
        r = v;
        if (size == SZ_BYTE) r = {{24{v[7]}}, v[7:0]};
        else if (size == SZ_WORD) r = {{16{v[15]}}, v[15:0]};
        return r;
    endfunction

    // mode in [5:2], size in [1:0]
    function automatic logic [5:0] mem_split(input logic [6:0] op);
        logic [5:0] r;
        r = '0;
        for (int m = 0; m < 10; m++) begin
            if (op >= 7'(7 + 3 * m) && op < 7'(10 + 3 * m)) begin
                r = {4'(m), 2'(op - 7'(7 + 3 * m))};
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] check_access(input logic [31:0] addr,
                                                input logic [1:0]  size,
                                                input logic [31:0] base);
        logic [31:0] off;
        logic [32:0] last;
        logic [2:0]  w;
        logic [2:0]  r;
        w    = 3'd1 << size;
        off  = addr - base;
        last = {1'b0, off} + 33'(w);
        r    = ST_OK;
        if ((size == SZ_WORD && addr[0]) || (size == SZ_LONG && addr[1:0] != 2'd0))
            r = ST_MISALIGN;
        else if (addr < base)
            r = ST_BELOW;
        else if (last > 33'(MEM_BYTES))
            r = ST_OUTSIDE;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rie_dmem.sv =====
// ----------------------------------------------------------------------------
// rie_dmem
// Byte-addressed little-endian data memory in four byte banks; an access
// may start at any byte offset. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rie_dmem
    import rie_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_mem_req    i_req,
    output logic [31:0]      o_rdata
);

    logic [1:0] r_off_lo;
    logic [7:0] r_dout [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0]       r_mem [ROWS];
        logic [1:0]       k;
        logic [OFF_W-1:0] baddr;
        logic [ROW_W-1:0] row;
        logic             lane_on;

        assign k       = 2'(b) - i_req.off[1:0];
        assign baddr   = i_req.off + OFF_W'(k);
        assign row     = baddr[OFF_W-1:2];
        assign lane_on = (i_req.size == SZ_LONG) ||
                         (i_req.size == SZ_WORD && k[1] == 1'b0) ||
                         (k == 2'd0);

        always_ff @(posedge i_clk) begin
            if (i_req.wr_en && lane_on) begin
                r_mem[row] <= i_req.wdata[8*k +: 8];
            end
            if (i_req.rd_en) begin
                r_dout[b] <= r_mem[row];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_off_lo <= i_req.off[1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_rdata[8*k +: 8] = r_dout[2'(r_off_lo + 2'(k))];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/risc_ir_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// risc_ir_instruction_executor
// Integer execute unit: one decoded instruction per request, with register
// file, T flag, return register and byte data memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  request   in         i_valid / o_stall   opcode, indices, imm, addresses
//  result    out        o_valid / i_stall   status, T, reg write, transfer
//  config    in         APB write/read      memory_base, global_base
//
//  One request per cycle while o_stall is low; a result appears in the cycle
//  after it is accepted. Memory reads use the registered data memory read;
//  load data is forwarded to the next request's register reads.
//  Reset clears registers, T, return register and config; memory is not.
//  A held result blocks new requests only while i_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module risc_ir_instruction_executor
    import rie_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [6:0]  i_opcode,
    input  wire logic [7:0]  i_dst_index,
    input  wire logic [7:0]  i_src_index,
    input  wire logic [31:0] i_immediate,
    input  wire logic [31:0] i_target_address,
    input  wire logic [31:0] i_instr_address,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic             o_t_flag,
    output logic             o_reg_written,
    output logic [3:0]       o_reg_index,
    output logic [31:0]      o_reg_value,
    output logic             o_transfer_latched,
    output logic [31:0]      o_transfer_target,
    output logic             o_transfer_conditional,
    output logic             o_transfer_taken,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0]      r_regs [REG_COUNT];
    logic             r_t;
    logic [31:0]      r_pr;
    logic [31:0]      r_mem_base;
    logic [31:0]      r_gbr;
    logic             r_ld_pend;
    logic [REG_W-1:0] r_ld_idx;
    logic [1:0]       r_ld_size;

    logic             r_s1_valid;
    logic             r_s1_load;
    logic [2:0]       r_s1_st;
    logic             r_s1_t;
    logic             r_s1_wr;
    logic [3:0]       r_s1_wi;
    logic [31:0]      r_s1_wv;
    logic             r_s1_tl;
    logic [31:0]      r_s1_tt;
    logic             r_s1_tc;
    logic             r_s1_tk;

    logic             accept;
    logic [31:0]      mem_rdata;
    logic [31:0]      ld_val;
    logic [REG_W-1:0] d_i;
    logic [REG_W-1:0] s_i;
    logic [31:0]      rd_v;
    logic [31:0]      rs_v;
    logic [31:0]      r0_v;
    logic             dok;
    logic             sok;
    logic [3:0]       mode;
    logic [1:0]       split_sz;
    logic [1:0]       msz;
    logic [31:0]      ma;
    logic [31:0]      moff;
    logic             need_d;
    logic             need_s;

    logic [2:0]       n_st;
    logic             n_t;
    logic             n_wr;
    logic [3:0]       n_wi;
    logic [31:0]      n_wv;
    logic             n_tl;
    logic [31:0]      n_tt;
    logic             n_tc;
    logic             n_tk;
    logic [31:0]      n_pr;
    logic             n_inc;
    logic             n_ld;
    logic             n_stm;
    logic [31:0]      n_sdata;
    t_mem_req         mreq;

    assign o_stall = r_s1_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    assign ld_val = sext(mem_rdata, r_ld_size);
    assign d_i    = i_dst_index[REG_W-1:0];
    assign s_i    = i_src_index[REG_W-1:0];
    assign dok    = (i_dst_index[7:REG_W] == '0);
    assign sok    = (i_src_index[7:REG_W] == '0);
    assign rd_v   = (r_ld_pend && r_ld_idx == d_i) ? ld_val : r_regs[d_i];
    assign rs_v   = (r_ld_pend && r_ld_idx == s_i) ? ld_val : r_regs[s_i];
    assign r0_v   = (r_ld_pend && r_ld_idx == '0) ? ld_val : r_regs[0];
    assign {mode, split_sz} = mem_split(i_opcode);

    always_comb begin
        need_d = (i_opcode >= OP_MOVT && i_opcode <= OP_MOV) ||
                 (i_opcode >= OP_ADD && i_opcode <= OP_SHRN) ||
                 (i_opcode >= OP_LDPCW && i_opcode <= OP_MOVA);
        need_s = i_opcode == OP_MOV ||
                 (i_opcode >= OP_ADD && i_opcode <= OP_OR && i_opcode != OP_CMPEQI &&
                  i_opcode != OP_CMPPZ && i_opcode != OP_CMPPL) ||
                 i_opcode == OP_NOT || i_opcode == OP_NEG ||
                 i_opcode == OP_JMP || i_opcode == OP_JSR;
    end

    always_comb begin
        n_st = ST_OK; n_t = r_t; n_wr = 1'b0; n_wi = '0; n_wv = '0;
        n_tl = 1'b0; n_tt = '0; n_tc = 1'b0; n_tk = 1'b0; n_pr = r_pr;
        n_inc = 1'b0; n_ld = 1'b0; n_stm = 1'b0; n_sdata = rs_v;
        ma = i_target_address;
        msz = split_sz;
        if (i_opcode >= OP_MEM_LO && i_opcode <= OP_MEM_HI) begin
            unique case (mode) inside
                MM_ST_IND:               ma = rd_v;
                MM_LD_IND, MM_LD_POST:   ma = rs_v;
                MM_ST_PRED:              ma = rd_v - (32'd1 << msz);
                MM_ST_DISP:              ma = rd_v + i_immediate;
                MM_LD_DISP:              ma = rs_v + i_immediate;
                MM_ST_IDX:               ma = r0_v + rd_v;
                MM_LD_IDX:               ma = r0_v + rs_v;
                default:                 ma = r_gbr + i_immediate;
            endcase
            if (mode < MM_ST_GBR && !(dok && sok)) begin
                n_st = ST_BAD_REG;
            end else begin
                n_st = check_access(ma, msz, r_mem_base);
                if (!mode[0]) begin
                    n_stm   = 1'b1;
                    n_sdata = (mode == MM_ST_GBR) ? r0_v : rs_v;
                    if (mode == MM_ST_PRED) begin
                        n_wr = 1'b1; n_wi = 4'(d_i); n_wv = ma;
                    end
                end else begin
                    n_ld = 1'b1;
                    n_wr = 1'b1;
                    n_wi = (mode == MM_LD_GBR) ? 4'd0 : 4'(d_i);
                    n_inc = (mode == MM_LD_POST) && (d_i != s_i);
                end
            end
        end else if ((need_d && !dok) || (need_s && !sok)) begin
            n_st = ST_BAD_REG;
        end else begin
            msz = SZ_LONG;
            unique case (i_opcode) inside
                OP_NOP:    ;
                OP_CLRT:   n_t = 1'b0;
                OP_SETT:   n_t = 1'b1;
                OP_MOVT:   begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = {31'd0, r_t}; end
                OP_MOVI:   begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = i_immediate; end
                OP_ADDI:   begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = rd_v + i_immediate; end
                OP_MOV:    begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = rs_v; end
                OP_ADD:    begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = rd_v + rs_v; end
                OP_SUB:    begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = rd_v - rs_v; end
                OP_CMPEQ:  n_t = (rd_v == rs_v);
                OP_CMPEQI: n_t = (rd_v == i_immediate);
                OP_CMPHS:  n_t = (rd_v >= rs_v);
                OP_CMPGE:  n_t = ($signed(rd_v) >= $signed(rs_v));
                OP_CMPHI:  n_t = (rd_v > rs_v);
                OP_CMPGT:  n_t = ($signed(rd_v) > $signed(rs_v));
                OP_CMPPZ:  n_t = ~rd_v[31];
                OP_CMPPL:  n_t = ~rd_v[31] && (rd_v != '0);
                OP_TST:    n_t = ((rd_v & rs_v) == '0);
                OP_AND:    begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = rd_v & rs_v; end
                OP_XOR:    begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = rd_v ^ rs_v; end
                OP_OR:     begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = rd_v | rs_v; end
                OP_TSTI:   n_t = ((rd_v & i_immediate) == '0);
                OP_ANDI:   begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = rd_v & i_immediate; end
                OP_XORI:   begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = rd_v ^ i_immediate; end
                OP_ORI:    begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = rd_v | i_immediate; end
                OP_NOT:    begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = ~rs_v; end
                OP_NEG:    begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = 32'd0 - rs_v; end
                OP_SHL1:   begin
                    n_t = rd_v[31]; n_wr = 1'b1; n_wi = 4'(d_i); n_wv = {rd_v[30:0], 1'b0};
                end
                OP_SHR1:   begin
                    n_t = rd_v[0]; n_wr = 1'b1; n_wi = 4'(d_i); n_wv = {1'b0, rd_v[31:1]};
                end
                OP_SAR1:   begin
                    n_t = rd_v[0]; n_wr = 1'b1; n_wi = 4'(d_i); n_wv = {rd_v[31], rd_v[31:1]};
                end
                OP_SHLN, OP_SHRN: begin
                    if (i_immediate != 32'd2 && i_immediate != 32'd8 &&
                        i_immediate != 32'd16) begin
                        n_st = ST_BAD_SHFT;
                    end else begin
                        n_wr = 1'b1; n_wi = 4'(d_i);
                        n_wv = (i_opcode == OP_SHLN) ? rd_v << i_immediate[4:0]
                                                     : rd_v >> i_immediate[4:0];
                    end
                end
                OP_BRA:    begin n_tl = 1'b1; n_tt = i_target_address; n_tk = 1'b1; end
                OP_BT:     begin
                    n_tl = 1'b1; n_tt = i_target_address; n_tc = 1'b1; n_tk = r_t;
                end
                OP_BF:     begin
                    n_tl = 1'b1; n_tt = i_target_address; n_tc = 1'b1; n_tk = ~r_t;
                end
                OP_BSR:    begin
                    n_pr = i_instr_address + 32'd4;
                    n_tl = 1'b1; n_tt = i_target_address; n_tk = 1'b1;
                end
                OP_JMP:    begin n_tl = 1'b1; n_tt = rs_v; n_tk = 1'b1; end
                OP_JSR:    begin
                    n_pr = i_instr_address + 32'd4;
                    n_tl = 1'b1; n_tt = rs_v; n_tk = 1'b1;
                end
                OP_RTS:    begin n_tl = 1'b1; n_tt = r_pr; n_tk = 1'b1; end
                OP_RTE:    n_st = ST_EXC_RET;
                OP_LDPCW, OP_LDPCL: begin
                    msz  = (i_opcode == OP_LDPCW) ? SZ_WORD : SZ_LONG;
                    n_st = check_access(i_target_address, msz, r_mem_base);
                    n_ld = 1'b1; n_wr = 1'b1; n_wi = 4'(d_i);
                end
                OP_MOVA:   begin n_wr = 1'b1; n_wi = 4'(d_i); n_wv = i_target_address; end
                default:   n_st = ST_UNKNOWN;
            endcase
        end
        if (n_st != ST_OK) begin
            n_t = r_t; n_wr = 1'b0; n_wi = '0; n_wv = '0;
            n_tl = 1'b0; n_tt = '0; n_tc = 1'b0; n_tk = 1'b0;
            n_pr = r_pr; n_inc = 1'b0; n_ld = 1'b0; n_stm = 1'b0;
        end
    end

    assign moff = ma - r_mem_base;

    always_comb begin
        mreq.rd_en = accept & n_ld;
        mreq.wr_en = accept & n_stm;
        mreq.off   = moff[OFF_W-1:0];
        mreq.size  = msz;
        mreq.wdata = n_sdata;
    end

    rie_dmem u_dmem (
        .i_clk   (i_clk),
        .i_req   (mreq),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) r_regs[i] <= '0;
            r_t        <= 1'b0;
            r_pr       <= '0;
            r_mem_base <= '0;
            r_gbr      <= '0;
            r_ld_pend  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2]) r_gbr <= pwdata;
                else          r_mem_base <= pwdata;
            end
            // retire the load issued last cycle
            if (r_ld_pend) r_regs[r_ld_idx] <= ld_val;
            r_ld_pend <= accept & n_ld;
            if (accept) begin
                r_t  <= n_t;
                r_pr <= n_pr;
                if (n_inc) r_regs[s_i] <= rs_v + (32'd1 << msz);
                if (n_wr && !n_ld) r_regs[n_wi[REG_W-1:0]] <= n_wv;
                r_s1_valid <= 1'b1;
            end else if (!i_stall) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ld_idx  <= n_wi[REG_W-1:0];
            r_ld_size <= msz;
            r_s1_load <= n_ld;
            r_s1_st   <= n_st;
            r_s1_t    <= n_t;
            r_s1_wr   <= n_wr;
            r_s1_wi   <= n_wi;
            r_s1_wv   <= n_wv;
            r_s1_tl   <= n_tl;
            r_s1_tt   <= n_tt;
            r_s1_tc   <= n_tc;
            r_s1_tk   <= n_tk;
        end
    end

    assign o_valid                = r_s1_valid;
    assign o_status               = r_s1_st;
    assign o_t_flag               = r_s1_t;
    assign o_reg_written          = r_s1_wr;
    assign o_reg_index            = r_s1_wi;
    assign o_reg_value            = r_s1_load ? ld_val : r_s1_wv;
    assign o_transfer_latched     = r_s1_tl;
    assign o_transfer_target      = r_s1_tt;
    assign o_transfer_conditional = r_s1_tc;
    assign o_transfer_taken       = r_s1_tk;

    assign prdata = paddr[2] ? r_gbr : r_mem_base;
    assign pready = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/rie_checker.sv =====
// ----------------------------------------------------------------------------
// rie_checker
// Port-level checks of the integer execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rie_checker
    import rie_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_status,
    input wire logic        o_reg_written,
    input wire logic [3:0]  o_reg_index,
    input wire logic [31:0] o_reg_value,
    input wire logic        o_transfer_latched,
    input wire logic        o_transfer_conditional,
    input wire logic        o_transfer_taken
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_reg_value) && $stable(o_status))
        else $error("held result changed");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> !o_reg_written && !o_transfer_latched)
        else $error("failed request wrote state");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_reg_written |-> o_reg_index == 4'd0 && o_reg_value == 32'd0)
        else $error("unused register fields not zero");

    a_uncond_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_transfer_latched && !o_transfer_conditional |-> o_transfer_taken)
        else $error("unconditional transfer not taken");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind risc_ir_instruction_executor rie_checker u_rie_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .o_valid                (o_valid),
    .i_stall                (i_stall),
    .o_status               (o_status),
    .o_reg_written          (o_reg_written),
    .o_reg_index            (o_reg_index),
    .o_reg_value            (o_reg_value),
    .o_transfer_latched     (o_transfer_latched),
    .o_transfer_conditional (o_transfer_conditional),
    .o_transfer_taken       (o_transfer_taken)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the integer execute unit. A directed list of
// requests covers opcode extremes, error codes, branches and several memory
// modes; random requests follow under several memory and global base
// settings. Results are checked against hand-written values in some directed
// rows, else a predictor of register file, T flag, return register, memory.
// ----------------------------------------------------------------------------
module tb;
    import rie_pkg::*;

    localparam logic [2:0] ADDR_MEMORY_BASE = 3'd0;
    localparam logic [2:0] ADDR_GLOBAL_BASE = 3'd4;
    localparam int         ITEMS_PER_PHASE  = 175;

    typedef struct packed {
        logic [6:0]  opcode;
        logic [7:0]  dst;
        logic [7:0]  src;
        logic [31:0] imm;
        logic [31:0] tgt;
        logic [31:0] ia;
    } t_instr;

    typedef struct packed {
        logic [2:0]  status;
        logic        t;
        logic        wr;
        logic [3:0]  widx;
        logic [31:0] wval;
        logic        tl;
        logic [31:0] ttgt;
        logic        tc;
        logic        tk;
    } t_result;

    typedef struct {
        t_instr  r;
        bit      typed;
        t_result e;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [6:0]  i_opcode = '0;
    logic [7:0]  i_dst_index = '0;
    logic [7:0]  i_src_index = '0;
    logic [31:0] i_immediate = '0;
    logic [31:0] i_target_address = '0;
    logic [31:0] i_instr_address = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic        o_t_flag;
    logic        o_reg_written;
    logic [3:0]  o_reg_index;
    logic [31:0] o_reg_value;
    logic        o_transfer_latched;
    logic [31:0] o_transfer_target;
    logic        o_transfer_conditional;
    logic        o_transfer_taken;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    risc_ir_instruction_executor DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_dst_index(i_dst_index), .i_src_index(i_src_index),
        .i_immediate(i_immediate), .i_target_address(i_target_address),
        .i_instr_address(i_instr_address),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_t_flag(o_t_flag), .o_reg_written(o_reg_written),
        .o_reg_index(o_reg_index), .o_reg_value(o_reg_value),
        .o_transfer_latched(o_transfer_latched), .o_transfer_target(o_transfer_target),
        .o_transfer_conditional(o_transfer_conditional),
        .o_transfer_taken(o_transfer_taken),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    logic [31:0] gpr [REG_COUNT];
    logic        t_q;
    logic [31:0] pr_q;
    logic [31:0] mem_base_q;
    logic [31:0] gbr_q;
    logic [7:0]  mem_img [MEM_BYTES];
    bit          mem_set [MEM_BYTES];

    t_result     pending_results[$];
    t_dir_row    dir_rows[$];
    int          fails = 0;
    int          checked = 0;
    int          sent = 0;
    int          burst_left = 0;
    int          rx_cycle = 0;
    t_result     got;
    t_result     want;

    function automatic logic [2:0] range_status(input logic [31:0] a, input int w);
        longint unsigned off;
        if (w > 1 && (a & (w - 1)) != 0) return ST_MISALIGN;
        if (a < mem_base_q) return ST_BELOW;
        off = a - mem_base_q;
        if (off + w > MEM_BYTES) return ST_OUTSIDE;
        return ST_OK;
    endfunction

    function automatic logic [31:0] mem_load(input logic [31:0] a, input int w,
                                             inout bit blank);
        logic [31:0] off;
        logic [31:0] v;
        off = a - mem_base_q;
        v = '0;
        for (int k = 0; k < w; k++) begin
            if (!mem_set[off + k]) blank = 1'b1;
            else v |= 32'(mem_img[off + k]) << (8 * k);
        end
        if (w == 1) v = {{24{v[7]}}, v[7:0]};
        else if (w == 2) v = {{16{v[15]}}, v[15:0]};
        return v;
    endfunction

    function automatic void mem_store(input logic [31:0] a, input int w,
                                      input logic [31:0] v);
        logic [31:0] off;
        off = a - mem_base_q;
        for (int k = 0; k < w; k++) begin
            mem_img[off + k] = v[8 * k +: 8];
            mem_set[off + k] = 1'b1;
        end
    endfunction

    // returns 1 when the request would read memory that was never written
    function automatic bit run_instruction(input t_instr r, input bit commit,
                                           output t_result o);
        bit          dok, sok, need_d, need_s, blank;
        logic [31:0] rd, rs, r0, a, wv, tt, newpr;
        logic [2:0]  st;
        logic        t, wr, tl, tc, tk;
        logic [3:0]  wi;
        int          mode, w, incr_idx, incr_w;
        dok = r.dst < 16;
        sok = r.src < 16;
        rd = gpr[r.dst[3:0]];
        rs = gpr[r.src[3:0]];
        r0 = gpr[0];
        st = ST_OK; t = t_q; wr = 0; wi = '0; wv = '0;
        tl = 0; tt = '0; tc = 0; tk = 0; newpr = pr_q;
        incr_idx = -1; incr_w = 0; blank = 0;
        if (r.opcode >= OP_MEM_LO && r.opcode <= OP_MEM_HI) begin
            mode = int'(r.opcode - OP_MEM_LO) / 3;
            w = 1 << (int'(r.opcode - OP_MEM_LO) % 3);
            if (mode < MM_ST_GBR && !(dok && sok)) begin
                st = ST_BAD_REG;
            end else begin
                case (mode)
                    MM_ST_IND:             a = rd;
                    MM_LD_IND, MM_LD_POST: a = rs;
                    MM_ST_PRED:            a = rd - w;
                    MM_ST_DISP:            a = rd + r.imm;
                    MM_LD_DISP:            a = rs + r.imm;
                    MM_ST_IDX:             a = r0 + rd;
                    MM_LD_IDX:             a = r0 + rs;
                    default:               a = gbr_q + r.imm;
                endcase
                st = range_status(a, w);
                if (st == ST_OK) begin
                    if (mode % 2 == 0) begin
                        if (commit) mem_store(a, w, mode == MM_ST_GBR ? r0 : rs);
                        if (mode == MM_ST_PRED) begin
                            wr = 1; wi = r.dst[3:0]; wv = a;
                        end
                    end else begin
                        wr = 1;
                        wi = (mode == MM_LD_GBR) ? 4'd0 : r.dst[3:0];
                        wv = mem_load(a, w, blank);
                        if (mode == MM_LD_POST && r.dst != r.src) begin
                            incr_idx = r.src; incr_w = w;
                        end
                    end
                end
            end
        end else begin
            need_d = (r.opcode >= OP_MOVT && r.opcode <= OP_MOV) ||
                     (r.opcode >= OP_ADD && r.opcode <= OP_SHRN) ||
                     (r.opcode >= OP_LDPCW && r.opcode <= OP_MOVA);
            need_s = r.opcode == OP_MOV || (r.opcode >= OP_ADD && r.opcode <= OP_OR &&
                     r.opcode != OP_CMPEQI && r.opcode != OP_CMPPZ &&
                     r.opcode != OP_CMPPL) || r.opcode == OP_NOT || r.opcode == OP_NEG ||
                     r.opcode == OP_JMP || r.opcode == OP_JSR;
            if ((need_d && !dok) || (need_s && !sok)) begin
                st = ST_BAD_REG;
            end else begin
                case (r.opcode)
                    OP_NOP:    ;
                    OP_CLRT:   t = 0;
                    OP_SETT:   t = 1;
                    OP_MOVT:   begin wr = 1; wi = r.dst[3:0]; wv = {31'b0, t}; end
                    OP_MOVI:   begin wr = 1; wi = r.dst[3:0]; wv = r.imm; end
                    OP_ADDI:   begin wr = 1; wi = r.dst[3:0]; wv = rd + r.imm; end
                    OP_MOV:    begin wr = 1; wi = r.dst[3:0]; wv = rs; end
                    OP_ADD:    begin wr = 1; wi = r.dst[3:0]; wv = rd + rs; end
                    OP_SUB:    begin wr = 1; wi = r.dst[3:0]; wv = rd - rs; end
                    OP_CMPEQ:  t = rd == rs;
                    OP_CMPEQI: t = rd == r.imm;
                    OP_CMPHS:  t = rd >= rs;
                    OP_CMPGE:  t = $signed(rd) >= $signed(rs);
                    OP_CMPHI:  t = rd > rs;
                    OP_CMPGT:  t = $signed(rd) > $signed(rs);
                    OP_CMPPZ:  t = !rd[31];
                    OP_CMPPL:  t = !rd[31] && rd != 0;
                    OP_TST:    t = (rd & rs) == 0;
                    OP_AND:    begin wr = 1; wi = r.dst[3:0]; wv = rd & rs; end
                    OP_XOR:    begin wr = 1; wi = r.dst[3:0]; wv = rd ^ rs; end
                    OP_OR:     begin wr = 1; wi = r.dst[3:0]; wv = rd | rs; end
                    OP_TSTI:   t = (rd & r.imm) == 0;
                    OP_ANDI:   begin wr = 1; wi = r.dst[3:0]; wv = rd & r.imm; end
                    OP_XORI:   begin wr = 1; wi = r.dst[3:0]; wv = rd ^ r.imm; end
                    OP_ORI:    begin wr = 1; wi = r.dst[3:0]; wv = rd | r.imm; end
                    OP_NOT:    begin wr = 1; wi = r.dst[3:0]; wv = ~rs; end
                    OP_NEG:    begin wr = 1; wi = r.dst[3:0]; wv = 32'd0 - rs; end
                    OP_SHL1:   begin t = rd[31]; wr = 1; wi = r.dst[3:0]; wv = rd << 1; end
                    OP_SHR1:   begin t = rd[0]; wr = 1; wi = r.dst[3:0]; wv = rd >> 1; end
                    OP_SAR1:   begin
                        t = rd[0]; wr = 1; wi = r.dst[3:0]; wv = {rd[31], rd[31:1]};
                    end
                    OP_SHLN, OP_SHRN: begin
                        if (r.imm != 2 && r.imm != 8 && r.imm != 16) begin
                            st = ST_BAD_SHFT;
                        end else begin
                            wr = 1; wi = r.dst[3:0];
                            wv = (r.opcode == OP_SHLN) ? rd << r.imm[4:0] : rd >> r.imm[4:0];
                        end
                    end
                    OP_BRA:    begin tl = 1; tt = r.tgt; tk = 1; end
                    OP_BT:     begin tl = 1; tt = r.tgt; tc = 1; tk = t; end
                    OP_BF:     begin tl = 1; tt = r.tgt; tc = 1; tk = !t; end
                    OP_BSR:    begin newpr = r.ia + 4; tl = 1; tt = r.tgt; tk = 1; end
                    OP_JMP:    begin tl = 1; tt = rs; tk = 1; end
                    OP_JSR:    begin newpr = r.ia + 4; tl = 1; tt = rs; tk = 1; end
                    OP_RTS:    begin tl = 1; tt = pr_q; tk = 1; end
                    OP_RTE:    st = ST_EXC_RET;
                    OP_LDPCW, OP_LDPCL: begin
                        w = (r.opcode == OP_LDPCW) ? 2 : 4;
                        st = range_status(r.tgt, w);
                        if (st == ST_OK) begin
                            wr = 1; wi = r.dst[3:0]; wv = mem_load(r.tgt, w, blank);
                        end
                    end
                    OP_MOVA:   begin wr = 1; wi = r.dst[3:0]; wv = r.tgt; end
                    default:   st = ST_UNKNOWN;
                endcase
            end
        end
        if (st != ST_OK) begin
            t = t_q; wr = 0; wi = '0; wv = '0; tl = 0; tt = '0; tc = 0; tk = 0;
        end else if (commit) begin
            t_q = t;
            pr_q = newpr;
            if (incr_idx >= 0) gpr[incr_idx] = gpr[incr_idx] + incr_w;
            if (wr) gpr[wi] = wv;
        end
        o = '{st, t, wr, wi, wv, tl, tt, tc, tk};
        return blank;
    endfunction

    function automatic t_instr mk(input logic [6:0] op, input logic [7:0] d,
                                  input logic [7:0] s, input logic [31:0] imm,
                                  input logic [31:0] tgt, input logic [31:0] ia);
        return '{op, d, s, imm, tgt, ia};
    endfunction

    function automatic logic [6:0] mem_op(input logic [3:0] mode, input logic [1:0] size);
        return OP_MEM_LO + 7'(3 * mode) + 7'(size);
    endfunction

    function automatic t_instr pick_instr();
        t_instr r;
        int     kind;
        kind = $urandom_range(0, 99);
        r = '{7'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom};
        if (kind < 10) return r;
        r.dst = 8'($urandom_range(0, 15));
        r.src = 8'($urandom_range(0, 15));
        if (kind < 22) begin
            r.opcode = OP_MOVI;
            r.imm = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 32))
                                                : mem_base_q + $urandom_range(0, 255);
            if ($urandom_range(0, 3) == 0) r.imm[1:0] = 2'b00;
        end else if (kind < 60) begin
            r.opcode = 7'($urandom_range(OP_MEM_LO, OP_MEM_HI));
            r.imm = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 64)) - 8;
        end else if (kind < 65) begin
            r.opcode = $urandom_range(0, 1) ? OP_LDPCW : OP_LDPCL;
            r.tgt = mem_base_q + $urandom_range(0, 255);
        end else begin
            r.opcode = 7'($urandom_range(0, 72));
            if ($urandom_range(0, 2) == 0) r.imm = 32'(2 << (2 * $urandom_range(0, 3)));
        end
        if ($urandom_range(0, 29) == 0) r.dst = 8'($urandom_range(16, 255));
        if ($urandom_range(0, 29) == 0) r.src = 8'($urandom_range(16, 255));
        return r;
    endfunction

    task automatic send_instr(input t_instr r, input bit typed, input t_result e);
        t_result pred;
        bit      blank;
        int      gap;
        i_valid <= 1'b1;
        i_opcode <= r.opcode;
        i_dst_index <= r.dst;
        i_src_index <= r.src;
        i_immediate <= r.imm;
        i_target_address <= r.tgt;
        i_instr_address <= r.ia;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        blank = run_instruction(r, 1'b1, pred);
        pending_results.push_back(typed ? e : pred);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== data) begin
            fails++;
            if (fails <= 10)
                $display("config readback @%0d: wrote %h read %h", addr, data, prdata);
        end
        psel <= 1'b0; penable <= 1'b0;
        if (addr == ADDR_MEMORY_BASE) mem_base_q = data;
        else gbr_q = data;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_status, o_t_flag, o_reg_written, o_reg_index, o_reg_value,
                    o_transfer_latched, o_transfer_target, o_transfer_conditional,
                    o_transfer_taken};
            checked++;
            if (pending_results.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unrequested result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fails++;
                    if (fails <= 10)
                        $display("result %0d mismatch\n  exp %p\n  got %p", checked, want, got);
                end
            end
        end
        rx_cycle++;
        case ((rx_cycle >> 6) % 4)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= rx_cycle[2];
        endcase
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [31:0] bases [4] = '{32'h0000_1000, 32'hFFFF_0000, 32'h8000_0000, 32'h0};
        logic [31:0] gbrs  [4] = '{32'h0000_1040, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0};
        t_instr      r;
        t_result     scratch;
        for (int k = 0; k < REG_COUNT; k++) gpr[k] = '0;
        t_q = 0; pr_q = '0; mem_base_q = '0; gbr_q = '0;
        foreach (mem_set[k]) mem_set[k] = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cfg_write(ADDR_MEMORY_BASE, 32'h0);
        cfg_write(ADDR_GLOBAL_BASE, 32'h0);

        dir_rows.push_back('{mk(OP_NOP, 0, 0, 0, 0, 0), 1, '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 0}});
        dir_rows.push_back('{mk(OP_SETT, 0, 0, 0, 0, 0), 1, '{ST_OK, 1, 0, 0, 0, 0, 0, 0, 0}});
        dir_rows.push_back('{mk(OP_MOVT, 3, 0, 0, 0, 0), 1, '{ST_OK, 1, 1, 3, 1, 0, 0, 0, 0}});
        dir_rows.push_back('{mk(OP_CLRT, 0, 0, 0, 0, 0), 1, '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 0}});
        dir_rows.push_back('{mk(7'h7F, 8'hFF, 8'hFF, '1, '1, '1), 1,
                             '{ST_UNKNOWN, 0, 0, 0, 0, 0, 0, 0, 0}});
        dir_rows.push_back('{mk(OP_ADD, 8'hFF, 0, 0, 0, 0), 1,
                             '{ST_BAD_REG, 0, 0, 0, 0, 0, 0, 0, 0}});
        dir_rows.push_back('{mk(OP_RTE, 0, 0, 0, 0, 0), 1, '{ST_EXC_RET, 0, 0, 0, 0, 0, 0, 0, 0}});
        dir_rows.push_back('{mk(OP_SHLN, 2, 0, 3, 0, 0), 1,
                             '{ST_BAD_SHFT, 0, 0, 0, 0, 0, 0, 0, 0}});
        dir_rows.push_back('{mk(OP_BRA, 0, 0, 0, '1, 0), 1, '{ST_OK, 0, 0, 0, 0, 1, '1, 0, 1}});
        dir_rows.push_back('{mk(OP_LDPCL, 0, 0, 0, 32'hFFFF_FFFC, 0), 1,
                             '{ST_OUTSIDE, 0, 0, 0, 0, 0, 0, 0, 0}});
        dir_rows.push_back('{mk(OP_MOVI, 1, 0, 32'h8000_0000, 0, 0), 1,
                             '{ST_OK, 0, 1, 1, 32'h8000_0000, 0, 0, 0, 0}});
        dir_rows.push_back('{mk(OP_MOVI, 2, 0, 32'h7FFF_FFFF, 0, 0), 1,
                             '{ST_OK, 0, 1, 2, 32'h7FFF_FFFF, 0, 0, 0, 0}});
        dir_rows.push_back('{mk(OP_ADD, 1, 2, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(OP_CMPGT, 2, 1, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(OP_SHRN, 1, 0, 16, 0, 0), 0, '0});
        dir_rows.push_back('{mk(mem_op(MM_ST_IND, SZ_LONG), 0, 2, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(mem_op(MM_LD_IND, SZ_BYTE), 4, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(mem_op(MM_LD_POST, SZ_LONG), 5, 5, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(mem_op(MM_LD_POST, SZ_WORD), 6, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(OP_MOVI, 7, 0, 1, 0, 0), 0, '0});
        dir_rows.push_back('{mk(mem_op(MM_ST_IND, SZ_LONG), 7, 1, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(OP_BT, 0, 0, 0, 32'h1234, 0), 0, '0});
        dir_rows.push_back('{mk(OP_BF, 0, 0, 0, 32'h5678, 0), 0, '0});
        dir_rows.push_back('{mk(OP_BSR, 0, 0, 0, 0, 32'hFFFF_FFFC), 0, '0});
        dir_rows.push_back('{mk(OP_RTS, 0, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(mem_op(MM_LD_GBR, SZ_WORD), 9, 9, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(OP_SAR1, 2, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(mem_op(MM_ST_PRED, SZ_BYTE), 0, 2, 0, 0, 0), 0, '0});
        foreach (dir_rows[k]) send_instr(dir_rows[k].r, dir_rows[k].typed, dir_rows[k].e);

        for (int p = 0; p < 4; p++) begin
            drain();
            cfg_write(ADDR_MEMORY_BASE, bases[p]);
            cfg_write(ADDR_GLOBAL_BASE, gbrs[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                do r = pick_instr(); while (run_instruction(r, 1'b0, scratch));
                send_instr(r, 1'b0, '0);
            end
        end

        drain();
        $display("Sent %0d requests (%0d directed) under four random base settings;",
                 sent, dir_rows.size());
        $display("%0d results checked.", checked);
        if (fails == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing", fails, pending_results.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
